FILE: rtl/hpx_pkg.sv
package hpx_pkg;

  localparam int PIX_W         = 36;
  localparam int PIX_BUS_W     = ((PIX_W + 7) / 8) * 8;
  localparam int MAX_ORDER_DEF = 16;
  localparam int ORDER_W       = 5;
  localparam int FRAC_W        = 30;
  localparam int ROOT_W        = 32;
  localparam int RAD_W         = 64;
  localparam int SQRT_STEPS    = 32;
  localparam int ANG_W         = 35;
  localparam int FACE_W        = 4;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd10;

  // Word index of the resolution order register on the configuration port.
  localparam logic REG_ORDER = 1'b0;

  typedef struct packed {
    logic              eq;
    logic              zneg;
    logic [1:0]        ntt;
    logic [FRAC_W-1:0] frac;
    logic [PIX_W-1:0]  eq_pix;
  } side_t;

endpackage

FILE: rtl/hpx_sqrt_step.sv
module hpx_sqrt_step #(
  parameter int STEP = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [hpx_pkg::RAD_W-1:0] rem_i,
  input  logic [hpx_pkg::RAD_W-1:0] root_i,
  input  hpx_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [hpx_pkg::RAD_W-1:0] rem_o,
  output logic [hpx_pkg::RAD_W-1:0] root_o,
  output hpx_pkg::side_t            side_o
);

  localparam logic [hpx_pkg::RAD_W-1:0] BIT =
    hpx_pkg::RAD_W'(1) << (hpx_pkg::RAD_W - 2 - 2 * STEP);

  logic [hpx_pkg::RAD_W-1:0] trial;
  logic                      take;
  logic                      valid_q;
  logic [hpx_pkg::RAD_W-1:0] rem_q;
  logic [hpx_pkg::RAD_W-1:0] root_q;
  hpx_pkg::side_t            side_q;

  // The root never has bits at or below the current trial bit, so OR equals add.
  assign trial = root_i | BIT;
  assign take  = (rem_i >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= take ? (rem_i - trial) : rem_i;
      root_q <= take ? ((root_i >> 1) | BIT) : (root_i >> 1);
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/hpx_pack.sv
module hpx_pack #(
  parameter int ORD_MAX = 16,
  parameter int K_W     = 5
) (
  input  logic [hpx_pkg::FACE_W-1:0] face_i,
  input  logic [ORD_MAX-1:0]         ix_i,
  input  logic [ORD_MAX-1:0]         iy_i,
  input  logic [K_W-1:0]             k_i,
  output logic [hpx_pkg::PIX_W-1:0]  pix_o
);

  logic [2*ORD_MAX-1:0] spread;

  always_comb begin
    spread = '0;
    for (int i = 0; i < ORD_MAX; i++) begin
      spread[2*i]   = ix_i[i];
      spread[2*i+1] = iy_i[i];
    end
  end

  assign pix_o = (hpx_pkg::PIX_W'(face_i) << {k_i, 1'b0}) + hpx_pkg::PIX_W'(spread);

endmodule

FILE: rtl/healpix_angle_to_nested_pixel.sv
// Throughput: one item per cycle; the 32-stage square-root pipeline, one root
// bit per stage, sets the latency, and the whole pipeline holds when the output
// stalls.
// Reset: asynchronous, active low; clears all valid bits and sets the
// resolution order to 10.
module healpix_angle_to_nested_pixel #(
  parameter int MAX_ORDER = hpx_pkg::MAX_ORDER_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] z_cos_colat, [63:32] longitude_turns
  input  logic [63:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [35:0] pixel_index, [39:36] zero
  output logic [hpx_pkg::PIX_BUS_W-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int K_W = $clog2(MAX_ORDER + 1);
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // Configuration.
  logic [hpx_pkg::ORDER_W-1:0] order_q;
  logic [K_W-1:0]              k_w;
  logic [MAX_ORDER-1:0]        mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= hpx_pkg::ORDER_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == hpx_pkg::REG_ORDER)) begin
      order_q <= pwdata[hpx_pkg::ORDER_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hpx_pkg::REG_ORDER) ? 32'(order_q) : 32'd0;

  assign k_w = (order_q > hpx_pkg::ORDER_W'(MAX_ORDER)) ? K_W'(MAX_ORDER)
                                                        : order_q[K_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      mask[i] = (i < int'(k_w));
    end
  end

  // Pipeline advance.
  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Front stage: saturation, region test and edge-line sums.
  logic signed [31:0]  z_raw;
  logic signed [31:0]  z_sat;
  logic [30:0]         z_abs;
  logic [32:0]         z_abs3;
  logic [30:0]         z_dist;
  logic [31:0]         w3;
  logic signed [35:0]  z_ext;
  logic signed [35:0]  z3;
  logic signed [35:0]  base;
  logic signed [35:0]  ap_full;
  logic signed [35:0]  am_full;

  assign z_raw   = signed'(s_axis_tdata[31:0]);
  assign z_sat   = (z_raw > ONE_Q30) ? ONE_Q30 : ((z_raw < -ONE_Q30) ? -ONE_Q30 : z_raw);
  assign z_abs   = z_sat[31] ? 31'(-z_sat) : z_sat[30:0];
  assign z_abs3  = 33'(z_abs) + {1'b0, z_abs, 1'b0};
  assign z_dist  = 31'(ONE_Q30) - z_abs;
  assign w3      = 32'(z_dist) + {z_dist, 1'b0};
  assign z_ext   = 36'(z_sat);
  assign z3      = z_ext + (z_ext <<< 1);
  assign base    = signed'({2'b00, s_axis_tdata[63:32], 2'b00}) + 36'sd2147483648;
  assign ap_full = base - z3;
  assign am_full = base + z3;

  logic                       s1_valid_q;
  logic                       s1_eq_q;
  logic                       s1_zneg_q;
  logic [1:0]                 s1_ntt_q;
  logic [hpx_pkg::FRAC_W-1:0] s1_frac_q;
  logic [hpx_pkg::ANG_W-1:0]  s1_ap_q;
  logic [hpx_pkg::ANG_W-1:0]  s1_am_q;
  logic [29:0]                s1_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_eq_q   <= (z_abs3 <= 33'd2147483648);
      s1_zneg_q <= z_sat[31];
      s1_ntt_q  <= s_axis_tdata[63:62];
      s1_frac_q <= s_axis_tdata[61:32];
      s1_ap_q   <= ap_full[hpx_pkg::ANG_W-1:0];
      s1_am_q   <= am_full[hpx_pkg::ANG_W-1:0];
      s1_w_q    <= w3[29:0];
    end
  end

  // Equatorial pixel, worked out beside the first root step.
  logic [2:0]                 ifp;
  logic [2:0]                 ifm;
  logic [hpx_pkg::ANG_W-1:0]  ap_sh;
  logic [hpx_pkg::ANG_W-1:0]  am_sh;
  logic [MAX_ORDER-1:0]       eq_jp;
  logic [MAX_ORDER-1:0]       eq_jm;
  logic [hpx_pkg::FACE_W-1:0] eq_face;
  logic [hpx_pkg::PIX_W-1:0]  eq_pix;

  assign ifp   = s1_ap_q[hpx_pkg::ANG_W-1:32];
  assign ifm   = s1_am_q[hpx_pkg::ANG_W-1:32];
  assign ap_sh = (s1_ap_q >> (32 - MAX_ORDER)) >> (K_W'(MAX_ORDER) - k_w);
  assign am_sh = (s1_am_q >> (32 - MAX_ORDER)) >> (K_W'(MAX_ORDER) - k_w);
  assign eq_jp = ap_sh[MAX_ORDER-1:0];
  assign eq_jm = am_sh[MAX_ORDER-1:0];

  always_comb begin
    if (ifp == ifm) begin
      eq_face = {1'b0, ifp} | 4'd4;
    end else if (ifp < ifm) begin
      eq_face = {1'b0, ifp};
    end else begin
      eq_face = {1'b0, ifm} + 4'd8;
    end
  end

  hpx_pack #(
    .ORD_MAX (MAX_ORDER),
    .K_W     (K_W)
  ) u_pack_eq (
    .face_i (eq_face),
    .ix_i   (eq_jm & mask),
    .iy_i   (~eq_jp & mask),
    .k_i    (k_w),
    .pix_o  (eq_pix)
  );

  // Square-root pipeline.
  logic [hpx_pkg::SQRT_STEPS:0] sq_valid;
  logic [hpx_pkg::RAD_W-1:0]    sq_rem  [hpx_pkg::SQRT_STEPS+1];
  logic [hpx_pkg::RAD_W-1:0]    sq_root [hpx_pkg::SQRT_STEPS+1];
  hpx_pkg::side_t               sq_side [hpx_pkg::SQRT_STEPS+1];

  assign sq_valid[0]        = s1_valid_q;
  assign sq_rem[0]          = {s1_w_q, 34'd0};
  assign sq_root[0]         = '0;
  assign sq_side[0].eq      = s1_eq_q;
  assign sq_side[0].zneg    = s1_zneg_q;
  assign sq_side[0].ntt     = s1_ntt_q;
  assign sq_side[0].frac    = s1_frac_q;
  assign sq_side[0].eq_pix  = eq_pix;

  for (genvar g = 0; g < hpx_pkg::SQRT_STEPS; g++) begin : g_sqrt
    hpx_sqrt_step #(
      .STEP (g)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .side_i  (sq_side[g]),
      .valid_o (sq_valid[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .side_o  (sq_side[g+1])
    );
  end

  // Multiply stage.
  logic [hpx_pkg::ROOT_W-1:0] root_s;
  hpx_pkg::side_t             sq_out;
  logic [hpx_pkg::FRAC_W:0]   frac_c;
  logic [62:0]                prod_m_full;
  logic                       mul_valid_q;
  logic [61:0]                mul_p_q;
  logic [61:0]                mul_m_q;
  hpx_pkg::side_t             mul_side_q;

  assign root_s      = sq_root[hpx_pkg::SQRT_STEPS][hpx_pkg::ROOT_W-1:0];
  assign sq_out      = sq_side[hpx_pkg::SQRT_STEPS];
  assign frac_c      = 31'(ONE_Q30) - {1'b0, sq_out.frac};
  assign prod_m_full = 63'(frac_c) * 63'(root_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= sq_valid[hpx_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_p_q    <= 62'(sq_out.frac) * 62'(root_s);
      mul_m_q    <= prod_m_full[61:0];
      mul_side_q <= sq_out;
    end
  end

  // Polar edge lines, clamp and face choice.
  logic [61:0]                jp_sh;
  logic [61:0]                jm_sh;
  logic [MAX_ORDER:0]         jp_wide;
  logic [MAX_ORDER:0]         jm_wide;
  logic [MAX_ORDER-1:0]       jp_c;
  logic [MAX_ORDER-1:0]       jm_c;
  logic                       j_valid_q;
  logic                       j_eq_q;
  logic [hpx_pkg::PIX_W-1:0]  j_eq_pix_q;
  logic [hpx_pkg::FACE_W-1:0] j_face_q;
  logic [MAX_ORDER-1:0]       j_ix_q;
  logic [MAX_ORDER-1:0]       j_iy_q;

  assign jp_sh   = (mul_p_q >> (62 - MAX_ORDER)) >> (K_W'(MAX_ORDER) - k_w);
  assign jm_sh   = (mul_m_q >> (62 - MAX_ORDER)) >> (K_W'(MAX_ORDER) - k_w);
  assign jp_wide = jp_sh[MAX_ORDER:0];
  assign jm_wide = jm_sh[MAX_ORDER:0];
  assign jp_c    = (jp_wide > {1'b0, mask}) ? mask : jp_wide[MAX_ORDER-1:0];
  assign jm_c    = (jm_wide > {1'b0, mask}) ? mask : jm_wide[MAX_ORDER-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_valid_q <= 1'b0;
    end else if (en) begin
      j_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_eq_q     <= mul_side_q.eq;
      j_eq_pix_q <= mul_side_q.eq_pix;
      if (mul_side_q.zneg) begin
        j_face_q <= {2'b10, mul_side_q.ntt};
        j_ix_q   <= jp_c;
        j_iy_q   <= jm_c;
      end else begin
        j_face_q <= {2'b00, mul_side_q.ntt};
        j_ix_q   <= ~jm_c & mask;
        j_iy_q   <= ~jp_c & mask;
      end
    end
  end

  // Output stage.
  logic [hpx_pkg::PIX_W-1:0] pol_pix;
  logic [hpx_pkg::PIX_W-1:0] out_pix_q;

  hpx_pack #(
    .ORD_MAX (MAX_ORDER),
    .K_W     (K_W)
  ) u_pack_pol (
    .face_i (j_face_q),
    .ix_i   (j_ix_q),
    .iy_i   (j_iy_q),
    .k_i    (k_w),
    .pix_o  (pol_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= j_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q <= j_eq_q ? j_eq_pix_q : pol_pix;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = hpx_pkg::PIX_BUS_W'(out_pix_q);

endmodule
